// ----- design/dnsax_pkg.sv -----
// Package for the DNS answer address extractor.
// Holds the result kind codes, the record constants and the result word type.
// No dependencies.
package dnsax_pkg;

  localparam int MaxMessageBytes = 512;
  localparam int PosW            = $clog2(MaxMessageBytes + 1);
  localparam int FifoDepth       = 4;
  localparam int PtrW            = $clog2(FifoDepth);
  localparam int CntW            = $clog2(FifoDepth + 1);

  localparam logic [15:0] TypeA    = 16'd1;
  localparam logic [15:0] TypeAaaa = 16'd28;
  localparam logic [15:0] ClassIn  = 16'd1;
  localparam logic [15:0] LenA     = 16'd4;
  localparam logic [15:0] LenAaaa  = 16'd16;

  typedef enum logic [2:0] {
    KindIpv4        = 3'd0,
    KindIpv6        = 3'd1,
    KindServerError = 3'd2,
    KindEndOk       = 3'd3,
    KindTruncated   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  rcode;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        run_end;
  } result_t;

endpackage

// ----- design/dns_answer_address_extractor.sv -----
// Top level of the DNS answer address extractor: byte parser and result queue.
// Depends on dnsax_pkg.
//
// Latency: a result word is written into the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while in_stall_o is low; a byte that causes two results writes both
// at once, and the single read port of the four-entry result queue then offers them one at a time.
// Reset: all parser state returns to the header phase and the queue empties at once.
module dns_answer_address_extractor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            msg_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            kind_o,
  output logic [3:0]            rcode_o,
  output logic [63:0]           addr_high_o,
  output logic [63:0]           addr_low_o,
  output logic                  run_end_o
);
  import dnsax_pkg::*;

  typedef enum logic [3:0] {
    PhHeader = 4'd0,
    PhQName  = 4'd1,
    PhQLabel = 4'd2,
    PhQPtr   = 4'd3,
    PhQTail  = 4'd4,
    PhAName  = 4'd5,
    PhALabel = 4'd6,
    PhAPtr   = 4'd7,
    PhAFixed = 4'd8,
    PhAData  = 4'd9,
    PhDone   = 4'd10
  } phase_e;

  phase_e            ph_q, ph_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [15:0]       fc_q, fc_d;
  logic [15:0]       qleft_q, qleft_d;
  logic [15:0]       aleft_q, aleft_d;
  logic [15:0]       rtype_q, rtype_d;
  logic [15:0]       rclass_q, rclass_d;
  logic [15:0]       dlen_q, dlen_d;
  logic [127:0]      shift_q, shift_d;
  logic              err_q, err_d;

  logic              h_valid;
  result_t           h_res;
  logic              l_valid;
  result_t           l_res;
  result_t           first_res, second_res;
  logic [1:0]        push_n;

  result_t           fifo_q [FifoDepth];
  logic [PtrW-1:0]   rd_ptr_q, wr_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              accept, pop;
  result_t           head;

  function automatic phase_e next_sec(logic [15:0] q, logic [15:0] a);
    phase_e p;
    if (q != 16'd0) begin
      p = PhQName;
    end else if (a != 16'd0) begin
      p = PhAName;
    end else begin
      p = PhDone;
    end
    return p;
  endfunction

  assign in_stall_o  = cnt_q > CntW'(FifoDepth - 2);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    ph_d     = ph_q;
    pos_d    = pos_q;
    fc_d     = fc_q;
    qleft_d  = qleft_q;
    aleft_d  = aleft_q;
    rtype_d  = rtype_q;
    rclass_d = rclass_q;
    dlen_d   = dlen_q;
    shift_d  = shift_q;
    err_d    = err_q;
    h_valid  = 1'b0;
    h_res    = '{kind: KindTruncated, rcode: 4'd0, addr_high: 64'd0, addr_low: 64'd0,
                 run_end: 1'b0};
    l_valid  = 1'b0;
    l_res    = h_res;

    if (pos_q >= PosW'(MaxMessageBytes)) begin
      if (!err_q) begin
        err_d   = 1'b1;
        h_valid = 1'b1;
      end
    end else begin
      if (!err_q) begin
        unique case (ph_q)
          PhHeader: begin
            if (pos_q == PosW'(3)) begin
              if (msg_byte_i[3:0] != 4'd0) begin
                err_d       = 1'b1;
                h_valid     = 1'b1;
                h_res.kind  = KindServerError;
                h_res.rcode = msg_byte_i[3:0];
              end
            end else if (pos_q == PosW'(4)) begin
              qleft_d = {msg_byte_i, 8'd0};
            end else if (pos_q == PosW'(5)) begin
              qleft_d = {qleft_q[15:8], msg_byte_i};
            end else if (pos_q == PosW'(6)) begin
              aleft_d = {msg_byte_i, 8'd0};
            end else if (pos_q == PosW'(7)) begin
              aleft_d = {aleft_q[15:8], msg_byte_i};
            end else if (pos_q == PosW'(11)) begin
              ph_d = next_sec(qleft_q, aleft_q);
            end
          end
          PhQName, PhAName: begin
            if (msg_byte_i == 8'd0) begin
              fc_d = 16'd0;
              if (ph_q == PhAName) begin
                ph_d     = PhAFixed;
                rtype_d  = 16'd0;
                rclass_d = 16'd0;
                dlen_d   = 16'd0;
                shift_d  = 128'd0;
              end else begin
                ph_d = PhQTail;
              end
            end else if (msg_byte_i[7:6] == 2'b11) begin
              ph_d = (ph_q == PhAName) ? PhAPtr : PhQPtr;
            end else begin
              fc_d = {8'd0, msg_byte_i};
              ph_d = (ph_q == PhAName) ? PhALabel : PhQLabel;
            end
          end
          PhQLabel, PhALabel: begin
            fc_d = fc_q - 16'd1;
            if (fc_d == 16'd0) begin
              ph_d = (ph_q == PhALabel) ? PhAName : PhQName;
            end
          end
          PhQPtr: begin
            fc_d = 16'd0;
            ph_d = PhQTail;
          end
          PhAPtr: begin
            fc_d     = 16'd0;
            ph_d     = PhAFixed;
            rtype_d  = 16'd0;
            rclass_d = 16'd0;
            dlen_d   = 16'd0;
            shift_d  = 128'd0;
          end
          PhQTail: begin
            fc_d = fc_q + 16'd1;
            if (fc_d >= 16'd4) begin
              fc_d    = 16'd0;
              qleft_d = qleft_q - 16'd1;
              ph_d    = next_sec(qleft_d, aleft_q);
            end
          end
          PhAFixed: begin
            case (fc_q)
              16'd0:   rtype_d  = {msg_byte_i, 8'd0};
              16'd1:   rtype_d  = {rtype_q[15:8], msg_byte_i};
              16'd2:   rclass_d = {msg_byte_i, 8'd0};
              16'd3:   rclass_d = {rclass_q[15:8], msg_byte_i};
              16'd8:   dlen_d   = {msg_byte_i, 8'd0};
              16'd9:   dlen_d   = {dlen_q[15:8], msg_byte_i};
              default: ;
            endcase
            fc_d = fc_q + 16'd1;
            if (fc_d >= 16'd10) begin
              fc_d = dlen_d;
              if (dlen_d == 16'd0) begin
                aleft_d = aleft_q - 16'd1;
                ph_d    = next_sec(qleft_q, aleft_d);
              end else begin
                ph_d = PhAData;
              end
            end
          end
          PhAData: begin
            shift_d = {shift_q[119:0], msg_byte_i};
            fc_d    = fc_q - 16'd1;
            if (fc_d == 16'd0) begin
              if (rclass_q == ClassIn) begin
                if (rtype_q == TypeA && dlen_q == LenA) begin
                  h_valid        = 1'b1;
                  h_res.kind     = KindIpv4;
                  h_res.addr_low = {32'd0, shift_d[31:0]};
                end else if (rtype_q == TypeAaaa && dlen_q == LenAaaa) begin
                  h_valid         = 1'b1;
                  h_res.kind      = KindIpv6;
                  h_res.addr_high = shift_d[127:64];
                  h_res.addr_low  = shift_d[63:0];
                end
              end
              aleft_d = aleft_q - 16'd1;
              ph_d    = next_sec(qleft_q, aleft_d);
            end
          end
          PhDone: ;
          default: ;
        endcase
      end
      pos_d = pos_q + PosW'(1);
    end

    if (last_byte_i) begin
      if (!err_d) begin
        l_valid    = 1'b1;
        l_res.kind = (ph_d == PhDone) ? KindEndOk : KindTruncated;
      end
      ph_d     = PhHeader;
      pos_d    = '0;
      fc_d     = 16'd0;
      qleft_d  = 16'd0;
      aleft_d  = 16'd0;
      rtype_d  = 16'd0;
      rclass_d = 16'd0;
      dlen_d   = 16'd0;
      shift_d  = 128'd0;
      err_d    = 1'b0;
    end

    first_res          = h_valid ? h_res : l_res;
    second_res         = l_res;
    first_res.run_end  = !(h_valid && l_valid);
    second_res.run_end = 1'b1;
    if (!accept) begin
      push_n = 2'd0;
    end else begin
      push_n = 2'(h_valid) + 2'(l_valid);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PhHeader;
      pos_q    <= '0;
      fc_q     <= 16'd0;
      qleft_q  <= 16'd0;
      aleft_q  <= 16'd0;
      rtype_q  <= 16'd0;
      rclass_q <= 16'd0;
      dlen_q   <= 16'd0;
      shift_q  <= 128'd0;
      err_q    <= 1'b0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        ph_q     <= ph_d;
        pos_q    <= pos_d;
        fc_q     <= fc_d;
        qleft_q  <= qleft_d;
        aleft_q  <= aleft_d;
        rtype_q  <= rtype_d;
        rclass_q <= rclass_d;
        dlen_q   <= dlen_d;
        shift_q  <= shift_d;
        err_q    <= err_d;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      cnt_q    <= cnt_q + CntW'(push_n) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= first_res;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= second_res;
    end
  end

  assign head        = fifo_q[rd_ptr_q];
  assign kind_o      = head.kind;
  assign rcode_o     = head.rcode;
  assign addr_high_o = head.addr_high;
  assign addr_low_o  = head.addr_low;
  assign run_end_o   = head.run_end;

endmodule

// ----- tb/tb_dns_answer_address_extractor.sv -----
// Self-checking testbench for dns_answer_address_extractor: drives DNS response
// messages byte by byte and checks every result word against an in-bench predictor.
// Depends on dnsax_pkg and the design under test.
`timescale 1ns / 1ps

module tb_dns_answer_address_extractor;
  import dnsax_pkg::*;

  typedef enum logic [3:0] {
    PhHeader, PhQName, PhQLabel, PhQPtr, PhQTail,
    PhAName, PhALabel, PhAPtr, PhAFixed, PhAData, PhDone
  } parse_phase_e;

  class address_scoreboard;
    parse_phase_e phase;
    logic [9:0]   pos;
    logic [15:0]  count;
    logic [15:0]  q_left;
    logic [15:0]  a_left;
    logic [15:0]  rr_type;
    logic [15:0]  rr_class;
    logic [15:0]  rd_len;
    logic [127:0] shift;
    logic         err;
    result_t      step_q[$];
    result_t      expected_q[$];
    int unsigned  mismatches;
    int unsigned  words_seen;

    function new();
      clear_state();
      mismatches = 0;
      words_seen = 0;
    endfunction

    function void clear_state();
      phase = PhHeader;
      pos = '0;
      count = '0;
      q_left = '0;
      a_left = '0;
      rr_type = '0;
      rr_class = '0;
      rd_len = '0;
      shift = '0;
      err = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void emit(kind_e k, logic [3:0] rc, logic [63:0] hi, logic [63:0] lo);
      result_t w;
      w.kind = k;
      w.rcode = rc;
      w.addr_high = hi;
      w.addr_low = lo;
      w.run_end = 1'b0;
      step_q.push_back(w);
    endfunction

    function void next_section();
      if (q_left != 0) begin
        phase = PhQName;
      end else if (a_left != 0) begin
        phase = PhAName;
      end else begin
        phase = PhDone;
      end
    endfunction

    function void name_end(bit in_answer);
      count = '0;
      if (in_answer) begin
        phase = PhAFixed;
        rr_type = '0;
        rr_class = '0;
        rd_len = '0;
        shift = '0;
      end else begin
        phase = PhQTail;
      end
    endfunction

    function void name_start(logic [7:0] b, bit in_answer);
      if (b == 8'h00) begin
        name_end(in_answer);
      end else if (b[7:6] == 2'b11) begin
        phase = in_answer ? PhAPtr : PhQPtr;
      end else begin
        count = {8'h00, b};
        phase = in_answer ? PhALabel : PhQLabel;
      end
    endfunction

    function void answer_done();
      if (rr_class == ClassIn) begin
        if (rr_type == TypeA && rd_len == LenA) begin
          emit(KindIpv4, 4'h0, 64'h0, {32'h0, shift[31:0]});
        end else if (rr_type == TypeAaaa && rd_len == LenAaaa) begin
          emit(KindIpv6, 4'h0, shift[127:64], shift[63:0]);
        end
      end
      a_left = a_left - 16'd1;
      next_section();
    endfunction

    function void parse(logic [7:0] b);
      case (phase)
        PhHeader: begin
          case (pos)
            10'd3: begin
              if (b[3:0] != 4'h0) begin
                err = 1'b1;
                emit(KindServerError, b[3:0], 64'h0, 64'h0);
              end
            end
            10'd4: q_left = {b, 8'h00};
            10'd5: q_left[7:0] = b;
            10'd6: a_left = {b, 8'h00};
            10'd7: a_left[7:0] = b;
            10'd11: next_section();
            default: ;
          endcase
        end
        PhQName: name_start(b, 1'b0);
        PhAName: name_start(b, 1'b1);
        PhQLabel, PhALabel: begin
          count = count - 16'd1;
          if (count == 0) begin
            phase = (phase == PhQLabel) ? PhQName : PhAName;
          end
        end
        PhQPtr: name_end(1'b0);
        PhAPtr: name_end(1'b1);
        PhQTail: begin
          count = count + 16'd1;
          if (count >= 4) begin
            count = '0;
            q_left = q_left - 16'd1;
            next_section();
          end
        end
        PhAFixed: begin
          case (count)
            16'd0: rr_type[15:8] = b;
            16'd1: rr_type[7:0] = b;
            16'd2: rr_class[15:8] = b;
            16'd3: rr_class[7:0] = b;
            16'd8: rd_len[15:8] = b;
            16'd9: rd_len[7:0] = b;
            default: ;
          endcase
          count = count + 16'd1;
          if (count >= 10) begin
            count = rd_len;
            if (rd_len == 0) begin
              answer_done();
            end else begin
              phase = PhAData;
            end
          end
        end
        PhAData: begin
          shift = {shift[119:0], b};
          count = count - 16'd1;
          if (count == 0) begin
            answer_done();
          end
        end
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic is_last);
      step_q.delete();
      if (pos >= MaxMessageBytes) begin
        if (!err) begin
          err = 1'b1;
          emit(KindTruncated, 4'h0, 64'h0, 64'h0);
        end
      end else begin
        if (!err) begin
          parse(b);
        end
        pos = pos + 10'd1;
      end
      if (is_last) begin
        if (!err) begin
          emit((phase == PhDone) ? KindEndOk : KindTruncated, 4'h0, 64'h0, 64'h0);
        end
        clear_state();
      end
      if (step_q.size() > 0) begin
        step_q[step_q.size() - 1].run_end = 1'b1;
      end
      foreach (step_q[i]) begin
        expected_q.push_back(step_q[i]);
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: word %0d: %s", $realtime, words_seen, what);
      mismatches++;
    endtask

    task check_word(logic [2:0] kind, logic [3:0] rc, logic [63:0] hi, logic [63:0] lo,
                    logic re);
      result_t w;
      words_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word, kind %0d", kind));
      end else begin
        w = expected_q.pop_front();
        if (kind !== w.kind) begin
          report_mismatch($sformatf("kind expected %0d, got %0d", w.kind, kind));
        end
        if (rc !== w.rcode) begin
          report_mismatch($sformatf("rcode expected %0h, got %0h", w.rcode, rc));
        end
        if (hi !== w.addr_high) begin
          report_mismatch($sformatf("addr_high expected %0h, got %0h", w.addr_high, hi));
        end
        if (lo !== w.addr_low) begin
          report_mismatch($sformatf("addr_low expected %0h, got %0h", w.addr_low, lo));
        end
        if (re !== w.run_end) begin
          report_mismatch($sformatf("run_end expected %0b, got %0b", w.run_end, re));
        end
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  msg_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [3:0]  rcode_o;
  logic [63:0] addr_high_o;
  logic [63:0] addr_low_o;
  logic        run_end_o;

  address_scoreboard sb;
  logic [7:0]  msg_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_tab[4] = '{0, 78, 0, 10};
  int unsigned stall_tab[4] = '{0, 0, 78, 10};

  dns_answer_address_extractor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .msg_byte_i  (msg_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .rcode_o     (rcode_o),
    .addr_high_o (addr_high_o),
    .addr_low_o  (addr_low_o),
    .run_end_o   (run_end_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_word(kind_o, rcode_o, addr_high_o, addr_low_o, run_end_o);
      end
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    msg_byte_i <= b;
    last_byte_i <= is_last;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    sb.note_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_message();
    foreach (msg_q[i]) begin
      send_byte(msg_q[i], i == msg_q.size() - 1);
    end
  endtask

  task automatic push_random(int n);
    repeat (n) msg_q.push_back(8'($urandom));
  endtask

  task automatic add_name();
    int labels;
    int len;
    labels = $urandom_range(3);
    repeat (labels) begin
      len = ($urandom_range(29) == 0) ? $urandom_range(64, 191) : $urandom_range(1, 6);
      msg_q.push_back(8'(len));
      push_random(len);
    end
    if ($urandom_range(2) == 0) begin
      msg_q.push_back({2'b11, 6'($urandom)});
      push_random(1);
    end else begin
      msg_q.push_back(8'h00);
    end
  endtask

  task automatic add_answer();
    logic [15:0] t;
    logic [15:0] c;
    logic [15:0] len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      t = TypeA;
    end else if (pick < 85) begin
      t = TypeAaaa;
    end else begin
      t = 16'($urandom);
    end
    c = ($urandom_range(9) != 0) ? ClassIn : 16'($urandom_range(3));
    if (t == TypeA) begin
      len = ($urandom_range(7) != 0) ? LenA : 16'($urandom_range(20));
    end else if (t == TypeAaaa) begin
      len = ($urandom_range(7) != 0) ? LenAaaa : 16'($urandom_range(20));
    end else begin
      len = 16'($urandom_range(12));
    end
    add_name();
    msg_q.push_back(t[15:8]);
    msg_q.push_back(t[7:0]);
    msg_q.push_back(c[15:8]);
    msg_q.push_back(c[7:0]);
    push_random(4);
    msg_q.push_back(len[15:8]);
    msg_q.push_back(len[7:0]);
    push_random(len);
  endtask

  task automatic build_message(bit clean);
    int qd;
    int an;
    int keep;
    msg_q.delete();
    if (!clean && $urandom_range(19) == 0) begin
      push_random($urandom_range(1, 30));
    end else begin
      qd = $urandom_range(2);
      an = $urandom_range(4);
      push_random(3);
      msg_q.push_back({4'($urandom),
                       (!clean && $urandom_range(9) == 0) ? 4'($urandom_range(1, 15)) : 4'h0});
      msg_q.push_back((!clean && $urandom_range(24) == 0) ? 8'($urandom) : 8'h00);
      msg_q.push_back(8'(qd));
      msg_q.push_back((!clean && $urandom_range(24) == 0) ? 8'($urandom) : 8'h00);
      msg_q.push_back(8'(an));
      push_random(4);
      repeat (qd) begin
        add_name();
        push_random(4);
      end
      repeat (an) add_answer();
      if ($urandom_range(4) == 0) begin
        push_random($urandom_range(1, 8));
      end
      if (!clean && $urandom_range(9) == 0) begin
        keep = $urandom_range(1, msg_q.size());
        while (msg_q.size() > keep) void'(msg_q.pop_back());
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int target;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Server error flagged on the last byte, a bare header, then two early ends.
    msg_q = '{8'h00, 8'h00, 8'h80, 8'hFF};
    send_message();
    msg_q = '{8'hAB, 8'hCD, 8'h81, 8'h80, 8'h00, 8'h00,
              8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_message();
    msg_q = '{8'h5A, 8'h00};
    send_message();
    msg_q = '{8'hFF};
    send_message();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      bytes_sent = 0;
      if (ph == 0) begin
        hold_asked++;
      end
      if (ph == 1) begin
        // One message runs past the size limit.
        build_message(1'b1);
        target = $urandom_range(MaxMessageBytes + 1, MaxMessageBytes + 4);
        while (msg_q.size() < target) push_random(1);
        send_message();
      end
      while (bytes_sent < 450) begin
        build_message(1'b0);
        send_message();
      end
      wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
